@@ rtl/rcps_pkg.sv @@
// Package for the RC pulse scaler: register map, widths and the structs
// that move between the pipeline stages. No dependencies.
package rcps_pkg;

  localparam int unsigned PulseW = 15;
  localparam int unsigned DeadW  = 12;
  localparam int unsigned ValW   = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ExtW   = 18;   // signed width of all front-end differences

  // Divider geometry: 32-bit dividend, 16-bit divisor, 4 quotient bits per stage
  localparam int unsigned NumW         = 32;
  localparam int unsigned DenW         = 16;
  localparam int unsigned DivStages    = 8;
  localparam int unsigned BitsPerStage = NumW / DivStages;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] RegPulseMin  = 3'd0;
  localparam logic [2:0] RegPulseTrim = 3'd1;
  localparam logic [2:0] RegPulseMax  = 3'd2;
  localparam logic [2:0] RegDeadBand  = 3'd3;
  localparam logic [2:0] RegAngleMode = 3'd4;
  localparam logic [2:0] RegOutHigh   = 3'd5;
  localparam logic [2:0] RegOutLow    = 3'd6;
  localparam logic [2:0] RegInvert    = 3'd7;

  // Reset values
  localparam logic [PulseW-1:0] PulseMinRst  = 15'd2300;
  localparam logic [PulseW-1:0] PulseTrimRst = 15'd2645;
  localparam logic [PulseW-1:0] PulseMaxRst  = 15'd3740;
  localparam logic [DeadW-1:0]  DeadBandRst  = 12'd30;

  typedef struct packed {
    logic [PulseW-1:0]      pulse_min;
    logic [PulseW-1:0]      pulse_trim;
    logic [PulseW-1:0]      pulse_max;
    logic [DeadW-1:0]       dead_band;
    logic                   angle_mode;
    logic signed [ValW-1:0] out_high;
    logic signed [ValW-1:0] out_low;
    logic                   invert;
  } cfg_t;

  // Control that rides along with each transaction
  typedef struct packed {
    logic                   use_map;  // result is quotient + offs, else offs alone
    logic                   q_neg;    // quotient sign
    logic                   do_inv;   // negate before saturation
    logic signed [ExtW-1:0] offs;     // map offset, or the bypass value
  } ctl_t;

  typedef struct packed {
    logic [NumW-1:0] numq;  // dividend bits shift out the top, quotient bits in the bottom
    logic [DenW-1:0] rem;
    logic [DenW-1:0] den;
    ctl_t            ctl;
  } div_t;

endpackage

@@ rtl/rcps_regs.sv @@
// APB-style configuration registers of the RC pulse scaler.
// Depends on rcps_pkg.
module rcps_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcps_pkg::AddrW-1:0]   paddr,
  input  logic [rcps_pkg::DataW-1:0]   pwdata,
  output logic [rcps_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output rcps_pkg::cfg_t               cfg_o
);

  rcps_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min  <= rcps_pkg::PulseMinRst;
      cfg_q.pulse_trim <= rcps_pkg::PulseTrimRst;
      cfg_q.pulse_max  <= rcps_pkg::PulseMaxRst;
      cfg_q.dead_band  <= rcps_pkg::DeadBandRst;
      cfg_q.angle_mode <= 1'b1;
      cfg_q.out_high   <= '0;
      cfg_q.out_low    <= '0;
      cfg_q.invert     <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        rcps_pkg::RegPulseMin:  cfg_q.pulse_min  <= pwdata[rcps_pkg::PulseW-1:0];
        rcps_pkg::RegPulseTrim: cfg_q.pulse_trim <= pwdata[rcps_pkg::PulseW-1:0];
        rcps_pkg::RegPulseMax:  cfg_q.pulse_max  <= pwdata[rcps_pkg::PulseW-1:0];
        rcps_pkg::RegDeadBand:  cfg_q.dead_band  <= pwdata[rcps_pkg::DeadW-1:0];
        rcps_pkg::RegAngleMode: cfg_q.angle_mode <= pwdata[0];
        rcps_pkg::RegOutHigh:   cfg_q.out_high   <= $signed(pwdata[rcps_pkg::ValW-1:0]);
        rcps_pkg::RegOutLow:    cfg_q.out_low    <= $signed(pwdata[rcps_pkg::ValW-1:0]);
        rcps_pkg::RegInvert:    cfg_q.invert     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rcps_pkg::RegPulseMin:  prdata = {17'd0, cfg_q.pulse_min};
      rcps_pkg::RegPulseTrim: prdata = {17'd0, cfg_q.pulse_trim};
      rcps_pkg::RegPulseMax:  prdata = {17'd0, cfg_q.pulse_max};
      rcps_pkg::RegDeadBand:  prdata = {20'd0, cfg_q.dead_band};
      rcps_pkg::RegAngleMode: prdata = {31'd0, cfg_q.angle_mode};
      rcps_pkg::RegOutHigh:   prdata = {{16{cfg_q.out_high[15]}}, cfg_q.out_high};
      rcps_pkg::RegOutLow:    prdata = {{16{cfg_q.out_low[15]}}, cfg_q.out_low};
      rcps_pkg::RegInvert:    prdata = {31'd0, cfg_q.invert};
      default:                prdata = '0;
    endcase
  end

endmodule

@@ rtl/rcps_front.sv @@
// Front end of the scaler pipeline: segment select with operand
// differences (stage A), then magnitudes and the product (stage B).
// Depends on rcps_pkg.
module rcps_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [rcps_pkg::PulseW-1:0]   pulse_width_i,
  input  rcps_pkg::cfg_t                cfg_i,
  output logic                          out_valid_o,
  output rcps_pkg::div_t                out_o
);

  localparam int unsigned EW = rcps_pkg::ExtW;

  logic signed [EW-1:0] x_s, mn_s, tr_s, mx_s, db_s, hi_s, lo_s;
  logic signed [EW-1:0] th_s, tl_s, rtl_s;
  logic signed [EW-1:0] xa_d, dc_d, den_d;
  rcps_pkg::ctl_t       ctl_d;

  logic                 a_valid_q;
  logic signed [EW-1:0] xa_q, dc_q, den_q;
  rcps_pkg::ctl_t       ctl_q;

  logic [EW-1:0]                 xa_abs, dc_abs, den_abs;
  logic [30:0]                   prod;
  rcps_pkg::div_t                b_d;
  logic                          b_valid_q;
  rcps_pkg::div_t                b_q;

  assign x_s   = $signed({3'd0, pulse_width_i});
  assign mn_s  = $signed({3'd0, cfg_i.pulse_min});
  assign tr_s  = $signed({3'd0, cfg_i.pulse_trim});
  assign mx_s  = $signed({3'd0, cfg_i.pulse_max});
  assign db_s  = $signed({6'd0, cfg_i.dead_band});
  assign hi_s  = $signed({{2{cfg_i.out_high[15]}}, cfg_i.out_high});
  assign lo_s  = $signed({{2{cfg_i.out_low[15]}}, cfg_i.out_low});
  assign th_s  = tr_s + db_s;
  assign tl_s  = tr_s - db_s;
  assign rtl_s = mn_s + db_s;

  // Stage A: pick the segment and form x-a, d-c and b-a
  always_comb begin
    xa_d          = x_s - th_s;
    dc_d          = hi_s;
    den_d         = mx_s - th_s;
    ctl_d.use_map = 1'b0;
    ctl_d.q_neg   = 1'b0;
    ctl_d.do_inv  = cfg_i.invert;
    ctl_d.offs    = '0;
    if (cfg_i.angle_mode) begin
      priority if (tl_s == mn_s || mx_s == th_s) begin
        // zero span: flat zero, no inversion
        ctl_d.do_inv = 1'b0;
      end else if (x_s > th_s) begin
        ctl_d.use_map = 1'b1;
      end else if (x_s < tl_s) begin
        xa_d          = x_s - mn_s;
        den_d         = tl_s - mn_s;
        ctl_d.use_map = 1'b1;
        ctl_d.offs    = -hi_s;
      end else begin
        ctl_d.use_map = 1'b0;  // dead zone
      end
    end else begin
      xa_d          = x_s - rtl_s;
      dc_d          = hi_s - lo_s;
      den_d         = mx_s - rtl_s;
      ctl_d.offs    = lo_s;
      ctl_d.use_map = (x_s > rtl_s) && (mx_s != rtl_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q  <= xa_d;
    dc_q  <= dc_d;
    den_q <= den_d;
    ctl_q <= ctl_d;
    b_q   <= b_d;
  end

  // Stage B: sign/magnitude split and the 15x16 product
  assign xa_abs  = xa_q[EW-1]  ? EW'(-xa_q)  : EW'(xa_q);
  assign dc_abs  = dc_q[EW-1]  ? EW'(-dc_q)  : EW'(dc_q);
  assign den_abs = den_q[EW-1] ? EW'(-den_q) : EW'(den_q);
  assign prod    = xa_abs[14:0] * dc_abs[15:0];

  always_comb begin
    b_d           = '0;
    b_d.numq      = {1'b0, prod};
    b_d.rem       = '0;
    b_d.den       = den_abs[rcps_pkg::DenW-1:0];
    b_d.ctl       = ctl_q;
    b_d.ctl.q_neg = xa_q[EW-1] ^ dc_q[EW-1] ^ den_q[EW-1];
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

@@ rtl/rcps_div.sv @@
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Depends on rcps_pkg.
module rcps_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  rcps_pkg::div_t in_i,
  output logic           out_valid_o,
  output rcps_pkg::div_t out_o
);

  localparam int unsigned NS = rcps_pkg::DivStages;
  localparam int unsigned NW = rcps_pkg::NumW;
  localparam int unsigned DW = rcps_pkg::DenW;

  logic           v_q  [NS];
  rcps_pkg::div_t st_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    rcps_pkg::div_t src, nxt;
    logic           src_v;

    if (g == 0) begin : g_first
      assign src   = in_i;
      assign src_v = in_valid_i;
    end else begin : g_rest
      assign src   = st_q[g-1];
      assign src_v = v_q[g-1];
    end

    always_comb begin
      logic [DW:0] r17;
      logic        ge;
      nxt = src;
      for (int k = 0; k < rcps_pkg::BitsPerStage; k++) begin
        r17      = {nxt.rem, nxt.numq[NW-1]};
        ge       = r17 >= {1'b0, nxt.den};
        nxt.numq = {nxt.numq[NW-2:0], ge};
        nxt.rem  = ge ? DW'(r17 - {1'b0, nxt.den}) : r17[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[g] <= nxt;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_o       = st_q[NS-1];

endmodule

@@ rtl/rcps_back.sv @@
// Output stage: signs the quotient, adds the offset, inverts, saturates.
// Depends on rcps_pkg.
module rcps_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [rcps_pkg::NumW-1:0]           quot_i,
  input  rcps_pkg::ctl_t                      ctl_i,
  output logic                                done_o,
  output logic signed [rcps_pkg::ValW-1:0]    scaled_value_o
);

  logic [16:0]                      q_clip;
  logic signed [18:0]               q_s, offs_s, sum_s, res_s;
  logic signed [rcps_pkg::ValW-1:0] sat_d;
  logic                             done_q;
  logic signed [rcps_pkg::ValW-1:0] val_q;

  // Any quotient of 2^16 or more saturates whatever the offset
  assign q_clip = (|quot_i[rcps_pkg::NumW-1:16]) ? 17'h10000 : {1'b0, quot_i[15:0]};
  assign q_s    = ctl_i.q_neg ? -$signed({2'b0, q_clip}) : $signed({2'b0, q_clip});
  assign offs_s = $signed({ctl_i.offs[rcps_pkg::ExtW-1], ctl_i.offs});
  assign sum_s  = ctl_i.use_map ? q_s + offs_s : offs_s;
  assign res_s  = ctl_i.do_inv ? -sum_s : sum_s;

  always_comb begin
    priority if (res_s > 19'sd32767) begin
      sat_d = 16'sh7fff;
    end else if (res_s < -19'sd32768) begin
      sat_d = -16'sh8000;
    end else begin
      sat_d = res_s[rcps_pkg::ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= sat_d;
  end

  assign done_o         = done_q;
  assign scaled_value_o = val_q;

endmodule

@@ rtl/rc_pulse_to_scaled_value.sv @@
// RC pulse scaler, top level: maps a measured receiver pulse width to a
// saturated signed 16-bit control value (angle or range mode).
// Depends on rcps_pkg, rcps_regs, rcps_front, rcps_div, rcps_back.
//
// Usage:
//   - Input: a transaction is taken at each rising edge with start high
//     and busy low. busy stays low; a new pulse may be offered every
//     cycle, so the sustained rate is one pulse per clock.
//   - Output: done_o pulses for one cycle with scaled_value_o valid. The
//     result of a pulse passes through one select stage, one multiply
//     stage, eight divider stages of four quotient bits each and one
//     output stage.
//   - Results leave in the order pulses were taken; the receiver has no
//     stall, so nothing is held back and no transaction is ever dropped.
//   - Configuration: APB-style, register i at byte address 4*i, pready
//     tied high. Write only while no transaction is in flight.
//   - Reset (rst_ni low, asynchronous): registers go to their defaults
//     (min 2300, trim 2645, max 3740, dead band 30, angle mode, outputs 0,
//     no inversion) and all pipeline valid bits clear.
module rc_pulse_to_scaled_value (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcps_pkg::AddrW-1:0]        paddr,
  input  logic [rcps_pkg::DataW-1:0]        pwdata,
  output logic [rcps_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [rcps_pkg::PulseW-1:0]       pulse_width_i,
  output logic                              done_o,
  output logic signed [rcps_pkg::ValW-1:0]  scaled_value_o
);

  rcps_pkg::cfg_t cfg;
  logic           front_valid;
  rcps_pkg::div_t front_data;
  logic           div_valid;
  rcps_pkg::div_t div_data;

  // Fully pipelined, never back-pressured
  assign busy = 1'b0;

  rcps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Segment select, differences and product
  rcps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (start & ~busy),
    .pulse_width_i (pulse_width_i),
    .cfg_i         (cfg),
    .out_valid_o   (front_valid),
    .out_o         (front_data)
  );

  // Truncating divide of the product magnitude by the span magnitude
  rcps_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_i        (front_data),
    .out_valid_o (div_valid),
    .out_o       (div_data)
  );

  // Offset, inversion and saturation
  rcps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (div_valid),
    .quot_i         (div_data.numq),
    .ctl_i          (div_data.ctl),
    .done_o         (done_o),
    .scaled_value_o (scaled_value_o)
  );

endmodule

@@ tb/rc_pulse_to_scaled_value_tb.sv @@
// Self-checking testbench for rc_pulse_to_scaled_value: drives pulse widths through the
// command-style input, programs the APB registers between phases and checks every result
// against a predictor of the scaling rules. Depends on rcps_pkg and the RTL only.
module rc_pulse_to_scaled_value_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;   // settle time after the last result
  localparam int unsigned RandPhases  = 20;
  localparam int unsigned PhaseItems  = 100;

  // DUT connections; the driven inputs are known from time zero
  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              psel           = 1'b0;
  logic                              penable        = 1'b0;
  logic                              pwrite         = 1'b0;
  logic [rcps_pkg::AddrW-1:0]        paddr          = '0;
  logic [rcps_pkg::DataW-1:0]        pwdata         = '0;
  logic [rcps_pkg::DataW-1:0]        prdata;
  logic                              pready;
  logic                              start          = 1'b0;
  logic                              busy;
  logic [rcps_pkg::PulseW-1:0]       pulse_width_i  = '0;
  logic                              done_o;
  logic signed [rcps_pkg::ValW-1:0]  scaled_value_o;

  // Testbench state
  rcps_pkg::cfg_t                    cfg_shadow;         // what the registers hold right now
  logic [rcps_pkg::PulseW-1:0]       pending_pulses[$];  // pulses not yet offered to the DUT
  logic signed [rcps_pkg::ValW-1:0]  expected_values[$]; // predicted results in flight
  int unsigned                       items_sent   = 0;
  int unsigned                       results_seen = 0;
  int unsigned                       errors       = 0;
  int unsigned                       cycle_cnt    = 0;
  bit                                gaps_on      = 1'b1;
  bit                                taken        = 1'b0; // transaction accepted at last edge

  rc_pulse_to_scaled_value u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .pulse_width_i  (pulse_width_i),
    .done_o         (done_o),
    .scaled_value_o (scaled_value_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // (x-a)*(d-c)/(b-a)+c; longint division truncates toward zero
  function automatic longint lin_map(longint x, longint a, longint b, longint c, longint d);
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  // All thresholds are formed in 64 bits so nothing wraps at the register widths.
  function automatic logic signed [rcps_pkg::ValW-1:0] scale_pulse(
      logic [rcps_pkg::PulseW-1:0] pw);
    longint x, mn, tr, mx, db, hi, lo, th, tl, r;
    bit     inv_ok;
    x      = longint'(pw);
    mn     = longint'(cfg_shadow.pulse_min);
    tr     = longint'(cfg_shadow.pulse_trim);
    mx     = longint'(cfg_shadow.pulse_max);
    db     = longint'(cfg_shadow.dead_band);
    hi     = longint'($signed(cfg_shadow.out_high));
    lo     = longint'($signed(cfg_shadow.out_low));
    inv_ok = 1'b1;
    if (cfg_shadow.angle_mode) begin
      th = tr + db;
      tl = tr - db;
      if (tl == mn || mx == th) begin
        // a degenerate span forces zero and inversion is skipped
        r      = 0;
        inv_ok = 1'b0;
      end else if (x > th) begin
        r = lin_map(x, th, mx, 0, hi);
      end else if (x < tl) begin
        r = lin_map(x, mn, tl, -hi, 0);
      end else begin
        r = 0;
      end
    end else begin
      tl = mn + db;
      if (x > tl && mx != tl) begin
        r = lin_map(x, tl, mx, lo, hi);
      end else begin
        r = lo;
      end
    end
    if (inv_ok && cfg_shadow.invert) begin
      r = -r;
    end
    // saturate once, after the negation
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    return r[rcps_pkg::ValW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Monitor: samples on the rising edge, records accepted transactions and
  // compares each result against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    logic signed [rcps_pkg::ValW-1:0] want;
    if (!rst_ni) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (done_o) begin
        results_seen++;
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("result %0d with no pulse outstanding", scaled_value_o));
        end else begin
          want = expected_values.pop_front();
          if (scaled_value_o !== want) begin
            report_mismatch($sformatf("scaled_value got %0d exp %0d",
                                      scaled_value_o, want));
          end
        end
      end
      // predict after the compare so this edge's result never meets its own entry
      if (start && !busy) begin
        expected_values.push_back(scale_pulse(pulse_width_i));
      end
    end
  end

  // Hard stop in case a result never arrives
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("rc_pulse_to_scaled_value test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (!gaps_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  // Inputs change on the falling edge; an offered pulse holds until accepted.
  always @(negedge clk_i) begin : driver
    int unsigned gap_left;
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left = 0;
    end else if (start && !taken) begin
      // not yet accepted: hold start and data
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left--;
    end else if (pending_pulses.size() != 0) begin
      start         <= 1'b1;
      pulse_width_i <= pending_pulses.pop_front();
      gap_left      = draw_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------------

  // One APB write: setup cycle, access cycle, done at the edge with pready high.
  // Upper pwdata bits carry junk now and then; the DUT must ignore them.
  task automatic apb_write(logic [2:0] idx, logic [rcps_pkg::DataW-1:0] val,
                           logic [rcps_pkg::DataW-1:0] mask);
    logic [rcps_pkg::DataW-1:0] data;
    data = val & mask;
    if ($urandom_range(0, 3) == 0) begin
      data = data | ($urandom() & ~mask);
    end
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program every register and mirror the new values
  task automatic load_config(rcps_pkg::cfg_t c);
    apb_write(rcps_pkg::RegPulseMin,  rcps_pkg::DataW'(c.pulse_min),  32'h0000_7fff);
    apb_write(rcps_pkg::RegPulseTrim, rcps_pkg::DataW'(c.pulse_trim), 32'h0000_7fff);
    apb_write(rcps_pkg::RegPulseMax,  rcps_pkg::DataW'(c.pulse_max),  32'h0000_7fff);
    apb_write(rcps_pkg::RegDeadBand,  rcps_pkg::DataW'(c.dead_band),  32'h0000_0fff);
    apb_write(rcps_pkg::RegAngleMode, rcps_pkg::DataW'(c.angle_mode), 32'h0000_0001);
    apb_write(rcps_pkg::RegOutHigh,   {16'h0, c.out_high},            32'h0000_ffff);
    apb_write(rcps_pkg::RegOutLow,    {16'h0, c.out_low},             32'h0000_ffff);
    apb_write(rcps_pkg::RegInvert,    rcps_pkg::DataW'(c.invert),     32'h0000_0001);
    cfg_shadow = c;
  endtask

  task automatic queue_pulse(int unsigned pw);
    pending_pulses.push_back(pw[rcps_pkg::PulseW-1:0]);
    items_sent++;
  endtask

  // Wait until every queued pulse has come back, then let the pipe settle
  task automatic wait_idle();
    while (results_seen < items_sent) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic rcps_pkg::cfg_t make_cfg(int unsigned mn, int unsigned tr,
                                              int unsigned mx, int unsigned db, bit ang,
                                              int hi, int lo, bit inv);
    rcps_pkg::cfg_t c;
    c.pulse_min  = mn[rcps_pkg::PulseW-1:0];
    c.pulse_trim = tr[rcps_pkg::PulseW-1:0];
    c.pulse_max  = mx[rcps_pkg::PulseW-1:0];
    c.dead_band  = db[rcps_pkg::DeadW-1:0];
    c.angle_mode = ang;
    c.out_high   = hi[rcps_pkg::ValW-1:0];
    c.out_low    = lo[rcps_pkg::ValW-1:0];
    c.invert     = inv;
    return c;
  endfunction

  // Random settings: mostly plausible stick geometry, some degenerate spans,
  // some fully random (reversed spans, thresholds past the pulse range).
  function automatic rcps_pkg::cfg_t rand_cfg();
    rcps_pkg::cfg_t c;
    int unsigned    mn, tr, mx, db, kind;
    int             hi, lo;
    kind = $urandom_range(0, 9);
    db   = $urandom_range(0, 200);
    mn   = $urandom_range(500, 20000);
    tr   = mn + db + $urandom_range(1, 3000);
    mx   = tr + db + $urandom_range(1, 3000);
    hi   = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 65535) - 32768;
    lo   = $urandom_range(0, 1) ? -$urandom_range(0, 2000) : $urandom_range(0, 65535) - 32768;
    if (kind == 0) begin
      // angle span collapses below trim
      mn = tr - db;
    end else if (kind == 1) begin
      // angle span collapses above trim
      mx = tr + db;
    end else if (kind == 2) begin
      // range span collapses
      mx = mn + db;
    end else if (kind == 3) begin
      mn = $urandom_range(0, 32767);
      tr = $urandom_range(0, 32767);
      mx = $urandom_range(0, 32767);
      db = $urandom_range(0, 4095);
    end else if (kind == 4) begin
      // reversed geometry
      mx = mn - $urandom_range(1, 400);
    end
    c = make_cfg(mn, tr, mx, db, 1'($urandom_range(0, 1)), hi, lo,
                 1'($urandom_range(0, 1)));
    return c;
  endfunction

  // Pulses clustered around the break points of the current settings,
  // with a share drawn from the whole 15-bit range.
  function automatic int unsigned rand_pulse();
    int base, v;
    case ($urandom_range(0, 9))
      0:       base = int'(cfg_shadow.pulse_min);
      1:       base = int'(cfg_shadow.pulse_trim);
      2:       base = int'(cfg_shadow.pulse_max);
      3:       base = int'(cfg_shadow.pulse_trim) - int'(cfg_shadow.dead_band);
      4:       base = int'(cfg_shadow.pulse_trim) + int'(cfg_shadow.dead_band);
      5:       base = int'(cfg_shadow.pulse_min) + int'(cfg_shadow.dead_band);
      6, 7:    return $urandom_range(0, 32767);
      default: return $urandom_range(int'(cfg_shadow.pulse_min), int'(cfg_shadow.pulse_max));
    endcase
    v = base + $urandom_range(0, 40) - 20;
    if (v < 0) begin
      v = 0;
    end
    if (v > 32767) begin
      v = 32767;
    end
    return v;
  endfunction

  initial begin
    cfg_shadow = make_cfg(int'(rcps_pkg::PulseMinRst), int'(rcps_pkg::PulseTrimRst),
                          int'(rcps_pkg::PulseMaxRst), int'(rcps_pkg::DeadBandRst),
                          1'b1, 0, 0, 1'b0);
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, no writes yet
    queue_pulse(0);
    queue_pulse(32767);
    queue_pulse(2645);
    wait_idle();

    // Angle mode at full scale: each edge of the dead zone and the ends
    load_config(make_cfg(2300, 2645, 3740, 30, 1'b1, 32767, 0, 1'b0));
    queue_pulse(0);
    queue_pulse(2300);
    queue_pulse(2614);
    queue_pulse(2615);
    queue_pulse(2675);
    queue_pulse(2676);
    queue_pulse(3740);
    queue_pulse(32767);
    wait_idle();

    // Register extremes: thresholds past 15 bits, reversed span, -out_high of -32768
    load_config(make_cfg(0, 32767, 0, 4095, 1'b1, -32768, 32767, 1'b1));
    queue_pulse(0);
    queue_pulse(32767);
    queue_pulse(28672);
    wait_idle();

    // Zero angle span: output pinned to zero, inversion ignored
    load_config(make_cfg(2000, 2030, 4000, 30, 1'b1, 1000, -5, 1'b1));
    queue_pulse(0);
    queue_pulse(3000);
    wait_idle();

    // Range mode, zero span: out_low everywhere, inverted -32768 saturates high
    load_config(make_cfg(1000, 0, 1100, 100, 1'b0, 32767, -32768, 1'b1));
    queue_pulse(1100);
    queue_pulse(1101);
    queue_pulse(32767);
    queue_pulse(0);
    wait_idle();

    // Range mode across the whole pulse range
    load_config(make_cfg(0, 16384, 32767, 0, 1'b0, 32767, -32768, 1'b0));
    queue_pulse(0);
    queue_pulse(1);
    queue_pulse(32767);
    wait_idle();

    // Random phases, some without any input gaps
    for (int p = 0; p < RandPhases; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      load_config(rand_cfg());
      for (int n = 0; n < PhaseItems; n++) begin
        queue_pulse(rand_pulse());
      end
      wait_idle();
    end

    if (expected_values.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
    end
    if (errors == 0) begin
      $display("rc_pulse_to_scaled_value test passed");
    end else begin
      $display("rc_pulse_to_scaled_value test failed");
    end
    $finish;
  end

endmodule
